// ===== hw/rtl/dtbw_pkg.sv =====
// dtbw_pkg: types, token codes and constants for the device tree blob walker.
// No dependencies; used by device_tree_blob_walker.
package dtbw_pkg;

    localparam int DEF_MAX_DEPTH = 16;

    localparam logic [31:0] FDT_MAGIC = 32'hd00dfeed;

    localparam logic [31:0] TOK_BEGIN_NODE = 32'd1;
    localparam logic [31:0] TOK_END_NODE   = 32'd2;
    localparam logic [31:0] TOK_PROP       = 32'd3;
    localparam logic [31:0] TOK_NOP        = 32'd4;
    localparam logic [31:0] TOK_END        = 32'd9;

    typedef enum logic [2:0] {
        EV_BEGIN     = 3'd0,
        EV_END       = 3'd1,
        EV_PROP      = 3'd2,
        EV_TREE_END  = 3'd3,
        EV_BAD_MAGIC = 3'd4,
        EV_BAD_TOKEN = 3'd5,
        EV_DEPTH     = 3'd6
    } event_kind_t;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_HEADER = 3'd1,
        PH_SKIP   = 3'd2,
        PH_TOKEN  = 3'd3,
        PH_NAME   = 3'd4,
        PH_PLEN   = 3'd5,
        PH_PNAME  = 3'd6,
        PH_VALUE  = 3'd7
    } walk_phase_t;

    typedef struct packed {
        logic [31:0] blob_word;
        logic        start_of_blob;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  event_kind;
        logic [4:0]  nesting_depth;
        logic [31:0] name_offset;
        logic [31:0] value_offset;
        logic [31:0] value_length;
    } out_item_t;

endpackage

// ===== hw/rtl/device_tree_blob_walker.sv =====
// device_tree_blob_walker: streams a flattened device tree blob, one word per transfer,
// and emits node, property, end and error events. Depends on dtbw_pkg.
//
//  channel | ports                     | payload
//  s_      | s_valid s_ready s_data    | dtbw_pkg::in_item_t  (one blob word)
//  m_      | m_valid m_ready m_data    | dtbw_pkg::out_item_t (zero or one event per word)
//
// One word per cycle while s_ready is high; the phase decode and one 32-bit add/compare
// sit between the state registers and a two-entry output register (output plus skid).
// An event taken with its word is registered in the output entry, or in skid while that is full.
// s_ready drops only while both output entries are full.
// Synchronous active-low reset; the name stack holds no reset value.
module device_tree_blob_walker #(
    parameter int MAX_DEPTH = dtbw_pkg::DEF_MAX_DEPTH
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  dtbw_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output dtbw_pkg::out_item_t m_data
);

    localparam int DW = $clog2(MAX_DEPTH + 1);
    localparam int AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

    dtbw_pkg::walk_phase_t phase_reg, phase_next;
    logic [31:0]   off_reg, off_next;
    logic [31:0]   struct_reg, struct_next;
    logic [31:0]   strings_reg, strings_next;
    logic [DW-1:0] depth_reg, depth_next;
    logic [29:0]   skip_reg, skip_next;
    logic [31:0]   plen_reg, plen_next;
    logic [31:0]   tos_reg, tos_next;
    logic [31:0]   below_reg;
    logic [31:0]   stack_mem [MAX_DEPTH];

    logic          accept, start, take_tok, push_stack;
    logic [31:0]   w, plen_m1;
    logic [DW-1:0] depth_m1, rd_full;
    logic [AW-1:0] wr_idx, rd_idx;
    logic [31:0]   depth_ext;

    logic                ev_valid;
    dtbw_pkg::out_item_t ev;

    logic                out_valid_reg, skid_valid_reg;
    dtbw_pkg::out_item_t out_reg, skid_reg;
    logic                pop, push_ev;

    assign s_ready  = !skid_valid_reg;
    assign accept   = s_valid && s_ready;
    assign w        = s_data.blob_word;
    assign start    = s_data.start_of_blob;
    assign take_tok = !start && ((phase_reg == dtbw_pkg::PH_TOKEN) ||
                      ((phase_reg == dtbw_pkg::PH_SKIP) && (off_reg >= struct_reg)));
    // ceil(len/4) - 1 for a nonzero length is (len - 1) >> 2
    assign plen_m1  = plen_reg - 32'd1;
    assign depth_m1 = depth_reg - DW'(1);
    assign wr_idx   = depth_m1[AW-1:0];
    assign rd_full  = depth_next - DW'(2);
    assign rd_idx   = rd_full[AW-1:0];

    // next state
    always_comb begin
        phase_next   = phase_reg;
        off_next     = off_reg;
        struct_next  = struct_reg;
        strings_next = strings_reg;
        depth_next   = depth_reg;
        skip_next    = skip_reg;
        plen_next    = plen_reg;
        tos_next     = tos_reg;
        push_stack   = 1'b0;
        if (accept) begin
            if (start) begin
                depth_next   = '0;
                struct_next  = '0;
                strings_next = '0;
                skip_next    = '0;
                plen_next    = '0;
                off_next     = 32'd4;
                phase_next   = (w == dtbw_pkg::FDT_MAGIC) ? dtbw_pkg::PH_HEADER
                                                          : dtbw_pkg::PH_IDLE;
            end else begin
                if (phase_reg != dtbw_pkg::PH_IDLE) begin
                    off_next = off_reg + 32'd4;
                end
                if (take_tok) begin
                    phase_next = dtbw_pkg::PH_TOKEN;
                    case (w)
                        dtbw_pkg::TOK_BEGIN_NODE: begin
                            if (depth_reg == DW'(MAX_DEPTH)) begin
                                phase_next = dtbw_pkg::PH_IDLE;
                            end else begin
                                push_stack = (depth_reg != '0);
                                tos_next   = off_reg + 32'd4;
                                depth_next = depth_reg + DW'(1);
                                phase_next = dtbw_pkg::PH_NAME;
                            end
                        end
                        dtbw_pkg::TOK_END_NODE: begin
                            if (depth_reg == '0) begin
                                phase_next = dtbw_pkg::PH_IDLE;
                            end else begin
                                depth_next = depth_m1;
                                tos_next   = below_reg;
                            end
                        end
                        dtbw_pkg::TOK_PROP: phase_next = dtbw_pkg::PH_PLEN;
                        dtbw_pkg::TOK_NOP:  phase_next = dtbw_pkg::PH_TOKEN;
                        default:            phase_next = dtbw_pkg::PH_IDLE;
                    endcase
                end else begin
                    case (phase_reg)
                        dtbw_pkg::PH_HEADER: begin
                            if (off_reg == 32'd8) begin
                                struct_next = w;
                            end
                            if (off_reg == 32'd12) begin
                                strings_next = w;
                                phase_next   = dtbw_pkg::PH_SKIP;
                            end
                        end
                        dtbw_pkg::PH_NAME: begin
                            if (w[31:24] == 8'd0 || w[23:16] == 8'd0 ||
                                w[15:8] == 8'd0 || w[7:0] == 8'd0) begin
                                phase_next = dtbw_pkg::PH_TOKEN;
                            end
                        end
                        dtbw_pkg::PH_PLEN: begin
                            plen_next  = w;
                            phase_next = dtbw_pkg::PH_PNAME;
                        end
                        dtbw_pkg::PH_PNAME: begin
                            if (plen_reg == '0) begin
                                phase_next = dtbw_pkg::PH_TOKEN;
                            end else begin
                                skip_next  = plen_m1[31:2];
                                phase_next = dtbw_pkg::PH_VALUE;
                            end
                        end
                        dtbw_pkg::PH_VALUE: begin
                            if (skip_reg == '0) begin
                                phase_next = dtbw_pkg::PH_TOKEN;
                            end else begin
                                skip_next = skip_reg - 30'd1;
                            end
                        end
                        default: phase_next = phase_reg;
                    endcase
                end
            end
        end
    end

    assign depth_ext = 32'(depth_next);

    // event output
    always_comb begin
        ev_valid         = 1'b0;
        ev.event_kind    = dtbw_pkg::EV_BEGIN;
        ev.nesting_depth = depth_ext[4:0];
        ev.name_offset   = '0;
        ev.value_offset  = '0;
        ev.value_length  = '0;
        if (start) begin
            ev_valid      = (w != dtbw_pkg::FDT_MAGIC);
            ev.event_kind = dtbw_pkg::EV_BAD_MAGIC;
        end else if (take_tok) begin
            case (w)
                dtbw_pkg::TOK_BEGIN_NODE: begin
                    ev_valid = 1'b1;
                    if (depth_reg == DW'(MAX_DEPTH)) begin
                        ev.event_kind = dtbw_pkg::EV_DEPTH;
                    end else begin
                        ev.event_kind  = dtbw_pkg::EV_BEGIN;
                        ev.name_offset = off_reg + 32'd4;
                    end
                end
                dtbw_pkg::TOK_END_NODE: begin
                    ev_valid = 1'b1;
                    if (depth_reg == '0) begin
                        ev.event_kind = dtbw_pkg::EV_DEPTH;
                    end else begin
                        ev.event_kind  = dtbw_pkg::EV_END;
                        ev.name_offset = tos_reg;
                    end
                end
                dtbw_pkg::TOK_PROP, dtbw_pkg::TOK_NOP: ev_valid = 1'b0;
                dtbw_pkg::TOK_END: begin
                    ev_valid      = 1'b1;
                    ev.event_kind = dtbw_pkg::EV_TREE_END;
                end
                default: begin
                    ev_valid      = 1'b1;
                    ev.event_kind = dtbw_pkg::EV_BAD_TOKEN;
                end
            endcase
        end else if (phase_reg == dtbw_pkg::PH_PNAME) begin
            ev_valid        = 1'b1;
            ev.event_kind   = dtbw_pkg::EV_PROP;
            ev.name_offset  = strings_reg + w;
            ev.value_offset = off_reg + 32'd4;
            ev.value_length = plen_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= dtbw_pkg::PH_IDLE;
            off_reg     <= '0;
            struct_reg  <= '0;
            strings_reg <= '0;
            depth_reg   <= '0;
            skip_reg    <= '0;
            plen_reg    <= '0;
        end else begin
            phase_reg   <= phase_next;
            off_reg     <= off_next;
            struct_reg  <= struct_next;
            strings_reg <= strings_next;
            depth_reg   <= depth_next;
            skip_reg    <= skip_next;
            plen_reg    <= plen_next;
        end
    end

    // top of stack in a register, entries below it in memory; below_reg holds depth-2
    always_ff @(posedge aclk) begin
        tos_reg <= tos_next;
        if (push_stack) begin
            stack_mem[wr_idx] <= tos_reg;
        end
        if (push_stack && (wr_idx == rd_idx)) begin
            below_reg <= tos_reg;
        end else begin
            below_reg <= stack_mem[rd_idx];
        end
    end

    assign pop     = out_valid_reg && m_ready;
    assign push_ev = accept && ev_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (pop) begin
                if (skid_valid_reg) begin
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= push_ev;
                end else begin
                    out_valid_reg <= push_ev;
                end
            end else if (push_ev) begin
                if (out_valid_reg) begin
                    skid_valid_reg <= 1'b1;
                end else begin
                    out_valid_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            if (skid_valid_reg) begin
                out_reg <= skid_reg;
                if (push_ev) begin
                    skid_reg <= ev;
                end
            end else if (push_ev) begin
                out_reg <= ev;
            end
        end else if (push_ev) begin
            if (out_valid_reg) begin
                skid_reg <= ev;
            end else begin
                out_reg <= ev;
            end
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule
